>>> sv/pcde_pkg.sv
// Shared constants and types for the pin change debounce events block.
`default_nettype none

package pcde_pkg;

    localparam int unsigned PORT_W     = 8;
    localparam int unsigned TS_W       = 32;
    localparam int unsigned ADDR_W     = 7;
    localparam int unsigned PIN_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned MAX_EVENTS = 8;
    localparam int unsigned EVT_CNT_W  = 3;

    localparam logic [ADDR_W-1:0] ADDR_RESET = 7'd32;

    typedef enum logic [0:0] {
        CFG_DEBOUNCE = 1'b0,
        CFG_ADDRESS  = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic busy;
        logic fire;
    } emit_status_t;

endpackage

`default_nettype wire

>>> sv/pcde_lane.sv
// One pin lane: stored level, last edge time and the lockout check.
`default_nettype none

module pcde_lane #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  cur_level,
    input  wire logic [TIME_WIDTH-1:0] now,
    input  wire logic [TIME_WIDTH-1:0] debounce,
    input  wire logic                  wr_en,
    input  wire logic [TIME_WIDTH-1:0] wr_time,
    input  wire logic                  wr_level,
    output logic                       cand
);

    logic [TIME_WIDTH-1:0] edge_time_reg;
    logic [TIME_WIDTH-1:0] edge_time_next;
    logic                  level_reg;
    logic                  level_next;
    logic [TIME_WIDTH-1:0] elapsed;

    assign elapsed = now - edge_time_reg;
    assign cand    = (cur_level != level_reg) && (elapsed >= debounce);

    always_comb
    begin
        edge_time_next = edge_time_reg;
        level_next     = level_reg;
        if (wr_en)
        begin
            edge_time_next = wr_time;
            level_next     = wr_level;
        end
    end

    always_ff @(posedge clk)
    begin
        edge_time_reg <= edge_time_next;
        level_reg     <= level_next;
    end

endmodule

`default_nettype wire

>>> sv/pcde_merge.sv
// Merge stage: walks the accepted pins lowest first and issues one event beat a cycle unless a stalled beat holds.
`default_nettype none

module pcde_merge #(
    parameter int unsigned PIN_COUNT  = 8,
    parameter int unsigned TIME_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load,
    input  wire logic [PIN_COUNT-1:0]  cand_mask,
    input  wire logic [PIN_COUNT-1:0]  load_level,
    input  wire logic [TIME_WIDTH-1:0] load_time,
    input  wire logic                  out_stall,
    output pcde_pkg::emit_status_t     status,
    output logic [PIN_COUNT-1:0]       grant,
    output logic [TIME_WIDTH-1:0]      grant_time,
    output logic                       grant_level,
    output logic                       out_valid,
    output logic [(PIN_COUNT > 1 ? $clog2(PIN_COUNT) : 1)-1:0] out_pin,
    output logic                       out_level,
    output logic                       out_last
);

    localparam int unsigned PIN_W = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;

    logic [PIN_COUNT-1:0]            mask_reg;
    logic [PIN_COUNT-1:0]            mask_next;
    logic [pcde_pkg::EVT_CNT_W-1:0]  cnt_reg;
    logic [pcde_pkg::EVT_CNT_W-1:0]  cnt_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [PIN_COUNT-1:0]            lvl_reg;
    logic [TIME_WIDTH-1:0]           time_reg;
    logic [PIN_W-1:0]                out_pin_reg;
    logic                            out_level_reg;
    logic                            out_last_reg;

    logic [PIN_COUNT-1:0]            lowest;
    logic [PIN_COUNT-1:0]            rest;
    logic [PIN_W-1:0]                low_idx;
    logic                            busy;
    logic                            fire;
    logic                            last;

    assign busy   = (mask_reg != '0);
    assign fire   = busy && (!out_valid_reg || !out_stall);
    assign lowest = mask_reg & (~mask_reg + PIN_COUNT'(1));
    assign rest   = mask_reg & ~lowest;
    assign last   = (rest == '0) ||
                    (cnt_reg == pcde_pkg::EVT_CNT_W'(pcde_pkg::MAX_EVENTS - 1));

    always_comb
    begin
        low_idx = '0;
        for (int i = PIN_COUNT - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                low_idx = PIN_W'(i);
            end
        end
    end

    assign status.busy = busy;
    assign status.fire = fire;
    assign grant       = fire ? lowest : '0;
    assign grant_time  = time_reg;
    assign grant_level = lvl_reg[low_idx];

    always_comb
    begin
        mask_next      = mask_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (fire)
        begin
            out_valid_next = 1'b1;
            mask_next      = last ? '0 : rest;
            cnt_next       = last ? '0 : cnt_reg + 1'b1;
        end
        else if (load)
        begin
            mask_next = cand_mask;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !busy)
        begin
            lvl_reg  <= load_level;
            time_reg <= load_time;
        end
        if (fire)
        begin
            out_pin_reg   <= low_idx;
            out_level_reg <= lvl_reg[low_idx];
            out_last_reg  <= last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pin   = out_pin_reg;
    assign out_level = out_level_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

>>> sv/pin_change_debounce_events_unit.sv
// Top level of the pin change debounce events block.
//
// Input channel (in_valid / in_stall) carries one port sample: raw_port, active
// low, and a wrapping timestamp. Output channel (out_valid / out_stall) carries
// one event per beat: event_address, pin_index, pin_level and last_event.
// The configuration port writes debounce_ticks and device_address; write it
// only while no sample is in flight.
// A sample lands in an input register and is checked by all pin lanes at once
// when the merge stage is idle; the accepted pins then load into the merge
// stage, which registers each event onto the output.
// A sample gets one lane check, then one event per accepted pin from the merge
// stage, which issues one event a cycle unless a stalled beat holds the output;
// a sample with no accepted pin, or the first sample after reset, has no events.
// Reset clears the configuration to its defaults, drops any pending events and
// makes the next sample the first one, which only records levels and times.
// While out_stall is high the current event holds; the input register still
// takes one further sample, then in_stall rises until the merge stage drains.
`default_nettype none

module pin_change_debounce_events_unit #(
    parameter int unsigned PIN_COUNT  = 8,
    parameter int unsigned TIME_WIDTH = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic                                cfg_index,
    input  wire logic [pcde_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [pcde_pkg::PORT_W-1:0]         raw_port,
    input  wire logic [pcde_pkg::TS_W-1:0]           timestamp,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [pcde_pkg::ADDR_W-1:0]              event_address,
    output logic [pcde_pkg::PIN_IDX_W-1:0]           pin_index,
    output logic                                     pin_level,
    output logic                                     last_event
);

    localparam int unsigned PIN_W = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;

    logic [pcde_pkg::TS_W-1:0]     debounce_reg;
    logic [pcde_pkg::TS_W-1:0]     debounce_next;
    logic [pcde_pkg::ADDR_W-1:0]   address_reg;
    logic [pcde_pkg::ADDR_W-1:0]   address_next;
    logic                          in_full_reg;
    logic                          in_full_next;
    logic                          seen_first_reg;
    logic                          seen_first_next;
    logic [pcde_pkg::PORT_W-1:0]   raw_reg;
    logic [pcde_pkg::TS_W-1:0]     ts_reg;

    logic                          in_take;
    logic                          eval;
    logic                          init;
    logic                          load;
    logic [TIME_WIDTH-1:0]         now;
    logic [TIME_WIDTH-1:0]         debounce;
    logic [PIN_COUNT-1:0]          level;
    logic [PIN_COUNT-1:0]          cand_mask;
    logic [PIN_COUNT-1:0]          grant;
    logic [TIME_WIDTH-1:0]         grant_time;
    logic                          grant_level;
    pcde_pkg::emit_status_t        status;
    logic [PIN_W-1:0]              out_pin;

    assign eval     = in_full_reg && !status.busy;
    assign init     = eval && !seen_first_reg;
    assign load     = eval && seen_first_reg;
    assign in_stall = in_full_reg && !eval;
    assign in_take  = in_valid && !in_stall;

    assign now      = TIME_WIDTH'(ts_reg);
    assign debounce = TIME_WIDTH'(debounce_reg);

    always_comb
    begin
        debounce_next = debounce_reg;
        address_next  = address_reg;
        if (cfg_write)
        begin
            unique case (pcde_pkg::cfg_index_t'(cfg_index))
                pcde_pkg::CFG_DEBOUNCE: debounce_next = cfg_data;
                pcde_pkg::CFG_ADDRESS:  address_next  = cfg_data[pcde_pkg::ADDR_W-1:0];
            endcase
        end
        in_full_next = in_take ? 1'b1 : (eval ? 1'b0 : in_full_reg);
        seen_first_next = seen_first_reg || init;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= '0;
            address_reg    <= pcde_pkg::ADDR_RESET;
            in_full_reg    <= 1'b0;
            seen_first_reg <= 1'b0;
        end
        else
        begin
            debounce_reg   <= debounce_next;
            address_reg    <= address_next;
            in_full_reg    <= in_full_next;
            seen_first_reg <= seen_first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            raw_reg <= raw_port;
            ts_reg  <= timestamp;
        end
    end

    for (genvar p = 0; p < PIN_COUNT; p++)
    begin : g_lane
        if (p < pcde_pkg::PORT_W)
        begin : g_port
            assign level[p] = ~raw_reg[p];
        end
        else
        begin : g_fill
            assign level[p] = 1'b1;
        end

        pcde_lane #(
            .TIME_WIDTH (TIME_WIDTH)
        ) u_lane (
            .clk       (clk),
            .cur_level (level[p]),
            .now       (now),
            .debounce  (debounce),
            .wr_en     (init || grant[p]),
            .wr_time   (init ? now : grant_time),
            .wr_level  (init ? level[p] : grant_level),
            .cand      (cand_mask[p])
        );
    end

    pcde_merge #(
        .PIN_COUNT  (PIN_COUNT),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .cand_mask   (cand_mask),
        .load_level  (level),
        .load_time   (now),
        .out_stall   (out_stall),
        .status      (status),
        .grant       (grant),
        .grant_time  (grant_time),
        .grant_level (grant_level),
        .out_valid   (out_valid),
        .out_pin     (out_pin),
        .out_level   (pin_level),
        .out_last    (last_event)
    );

    assign event_address = address_reg;
    assign pin_index     = pcde_pkg::PIN_IDX_W'(out_pin);

endmodule

`default_nettype wire

>>> sv/pcde_checker.sv
// Port-level checks for the pin change debounce events block, bound to the top level.
`default_nettype none

module pcde_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            out_valid,
    input wire logic                            out_stall,
    input wire logic [pcde_pkg::ADDR_W-1:0]     event_address,
    input wire logic [pcde_pkg::PIN_IDX_W-1:0]  pin_index,
    input wire logic                            pin_level,
    input wire logic                            last_event
);

    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("event beat shown during reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pin_index) &&
            $stable(pin_level) && $stable(last_event))
        else $error("stalled event beat changed");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_event |=> out_valid)
        else $error("event run broken before its last beat");

    a_run_address: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_event |=> $stable(event_address))
        else $error("address changed inside an event run");

endmodule

bind pin_change_debounce_events_unit pcde_checker u_pcde_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_address (event_address),
    .pin_index     (pin_index),
    .pin_level     (pin_level),
    .last_event    (last_event)
);

`default_nettype wire

>>> dv/tb_pin_change_debounce_events_unit.sv
`timescale 1ns / 100ps
// Testbench for the pin change debounce events unit, checked beat by beat against a predictor.
module tb_pin_change_debounce_events_unit;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned RANDOM_ITEMS  = 420;
    localparam int unsigned PHASE_ITEMS   = 70;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned PROBE_ROWS    = 17;

    typedef struct packed {
        logic [pcde_pkg::ADDR_W-1:0]    addr;
        logic [pcde_pkg::PIN_IDX_W-1:0] pin;
        logic                           level;
        logic                           last;
    } pin_event_t;

    typedef struct packed {
        logic [pcde_pkg::PORT_W-1:0]     raw;
        logic [pcde_pkg::TS_W-1:0]       ts;
        logic [pcde_pkg::CFG_DATA_W-1:0] ticks;
        logic [pcde_pkg::ADDR_W-1:0]     addr;
        logic                            typed;
        logic [pcde_pkg::PORT_W-1:0]     mask;
    } probe_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b1;
    logic                            cfg_write = 1'b0;
    logic                            cfg_index = 1'b0;
    logic [pcde_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic [pcde_pkg::PORT_W-1:0]     raw_port = '0;
    logic [pcde_pkg::TS_W-1:0]       timestamp = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [pcde_pkg::ADDR_W-1:0]     event_address;
    logic [pcde_pkg::PIN_IDX_W-1:0]  pin_index;
    logic                            pin_level;
    logic                            last_event;

    // predictor state and its copy of the registers
    logic [pcde_pkg::CFG_DATA_W-1:0] gap_ticks = '0;
    logic [pcde_pkg::ADDR_W-1:0]     stamp_address = pcde_pkg::ADDR_RESET;
    logic                            primed = 1'b0;
    logic [pcde_pkg::PORT_W-1:0]     held_levels = '0;
    logic [pcde_pkg::TS_W-1:0]       edge_stamp [pcde_pkg::PORT_W];

    pin_event_t  fresh_events [$];
    pin_event_t  expected_events [$];
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned idle_pct = 38;

    probe_row_t probe_rows [PROBE_ROWS] = '{
        '{8'hFF, 32'h0000_0000, 32'd0,         7'd32,  1'b1, 8'h00},
        '{8'hFF, 32'h0000_0001, 32'd0,         7'd32,  1'b1, 8'h00},
        '{8'h00, 32'h0000_0002, 32'd0,         7'd32,  1'b1, 8'hFF},
        '{8'hFF, 32'h0000_0003, 32'd0,         7'd32,  1'b1, 8'hFF},
        '{8'hFE, 32'h0000_0004, 32'd0,         7'd32,  1'b1, 8'h01},
        '{8'h7F, 32'h0000_0005, 32'd0,         7'd32,  1'b1, 8'h81},
        '{8'h7F, 32'hFFFF_FFFF, 32'd0,         7'd32,  1'b1, 8'h00},
        '{8'h00, 32'd50,        32'd100,       7'h7F,  1'b0, 8'h00},
        '{8'h00, 32'd103,       32'd100,       7'h7F,  1'b0, 8'h00},
        '{8'h00, 32'd105,       32'd100,       7'h7F,  1'b0, 8'h00},
        '{8'hFF, 32'hFFFF_FFF0, 32'd100,       7'h7F,  1'b0, 8'h00},
        '{8'h00, 32'h0000_0050, 32'd100,       7'h7F,  1'b0, 8'h00},
        '{8'h00, 32'h0000_0054, 32'd100,       7'h7F,  1'b0, 8'h00},
        '{8'hFF, 32'h0000_1000, 32'hFFFF_FFFF, 7'h00,  1'b0, 8'h00},
        '{8'hFF, 32'h0000_0053, 32'hFFFF_FFFF, 7'h00,  1'b0, 8'h00},
        '{8'hAA, 32'h0000_0060, 32'd0,         7'h55,  1'b0, 8'h00},
        '{8'h55, 32'h0000_0060, 32'd0,         7'h55,  1'b0, 8'h00}
    };

    pin_change_debounce_events_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .raw_port      (raw_port),
        .timestamp     (timestamp),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_address (event_address),
        .pin_index     (pin_index),
        .pin_level     (pin_level),
        .last_event    (last_event)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic void debounce_sample(logic [pcde_pkg::PORT_W-1:0] raw,
                                            logic [pcde_pkg::TS_W-1:0] ts);
        logic [pcde_pkg::PORT_W-1:0] level;
        logic [pcde_pkg::PORT_W-1:0] taken;
        logic [pcde_pkg::TS_W-1:0]   elapsed;
        pin_event_t                  ev;
        level = ~raw;
        taken = '0;
        fresh_events.delete();
        if (!primed)
        begin
            primed = 1'b1;
            held_levels = level;
            for (int p = 0; p < pcde_pkg::PORT_W; p++)
                edge_stamp[p] = ts;
            return;
        end
        for (int p = 0; p < pcde_pkg::PORT_W; p++)
        begin
            elapsed = ts - edge_stamp[p];
            if (level[p] != held_levels[p] && elapsed >= gap_ticks)
            begin
                edge_stamp[p] = ts;
                taken[p] = 1'b1;
                ev.addr = stamp_address;
                ev.pin = p[pcde_pkg::PIN_IDX_W-1:0];
                ev.level = level[p];
                ev.last = 1'b0;
                fresh_events.push_back(ev);
            end
        end
        if (fresh_events.size() != 0)
        begin
            fresh_events[fresh_events.size()-1].last = 1'b1;
            held_levels = (held_levels & ~taken) | (level & taken);
        end
    endfunction

    task automatic send_sample(logic [pcde_pkg::PORT_W-1:0] raw,
                               logic [pcde_pkg::TS_W-1:0] ts, logic typed,
                               logic [pcde_pkg::PORT_W-1:0] mask);
        pin_event_t ev;
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        raw_port = raw;
        timestamp = ts;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        debounce_sample(raw, ts);
        if (typed)
        begin
            fresh_events.delete();
            for (int p = 0; p < pcde_pkg::PORT_W; p++)
            begin
                if (mask[p])
                begin
                    ev.addr = stamp_address;
                    ev.pin = p[pcde_pkg::PIN_IDX_W-1:0];
                    ev.level = ~raw[p];
                    ev.last = (mask >> (p + 1)) == 0;
                    fresh_events.push_back(ev);
                end
            end
        end
        foreach (fresh_events[k])
            expected_events.push_back(fresh_events[k]);
    endtask

    task automatic drain_events();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(pcde_pkg::cfg_index_t idx,
                             logic [pcde_pkg::CFG_DATA_W-1:0] value);
        drain_events();
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        case (idx)
            pcde_pkg::CFG_DEBOUNCE: gap_ticks = value;
            pcde_pkg::CFG_ADDRESS:  stamp_address = value[pcde_pkg::ADDR_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    always @(negedge clk)
    begin
        out_stall = $urandom_range(0, 99) < idle_pct;
    end

    always @(posedge clk)
    begin
        pin_event_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_events.size() == 0)
                report_mismatch("beat with nothing expected, pin_index", pin_index, 0);
            else
            begin
                want = expected_events.pop_front();
                if (event_address !== want.addr)
                    report_mismatch("event_address", event_address, want.addr);
                if (pin_index !== want.pin)
                    report_mismatch("pin_index", pin_index, want.pin);
                if (pin_level !== want.level)
                    report_mismatch("pin_level", pin_level, want.level);
                if (last_event !== want.last)
                    report_mismatch("last_event", last_event, want.last);
            end
        end
    end

    initial
    begin
        logic [pcde_pkg::PORT_W-1:0]     raw_now;
        logic [pcde_pkg::TS_W-1:0]       ts_now;
        logic [pcde_pkg::CFG_DATA_W-1:0] ticks_pick;
        int unsigned                     pick;
        int unsigned                     phase;
        #0.5;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (probe_rows[r])
        begin
            if (probe_rows[r].ticks != gap_ticks)
                write_reg(pcde_pkg::CFG_DEBOUNCE, probe_rows[r].ticks);
            if (probe_rows[r].addr != stamp_address)
                write_reg(pcde_pkg::CFG_ADDRESS,
                          {{(pcde_pkg::CFG_DATA_W-pcde_pkg::ADDR_W){1'b0}},
                           probe_rows[r].addr});
            send_sample(probe_rows[r].raw, probe_rows[r].ts, probe_rows[r].typed,
                        probe_rows[r].mask);
        end
        raw_now = probe_rows[PROBE_ROWS-1].raw;
        ts_now = probe_rows[PROBE_ROWS-1].ts;

        for (int unsigned i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % PHASE_ITEMS == 0)
            begin
                phase = i / PHASE_ITEMS;
                case (phase)
                    0: ticks_pick = 32'd0;
                    2: ticks_pick = 32'hFFFF_FFFF;
                    3: ticks_pick = $urandom;
                    5: ticks_pick = 32'd1;
                    default: ticks_pick = $urandom_range(1, 40);
                endcase
                write_reg(pcde_pkg::CFG_DEBOUNCE, ticks_pick);
                write_reg(pcde_pkg::CFG_ADDRESS, $urandom_range(0, 127));
                // hold both sides busy for one whole phase
                idle_pct = (phase == 4) ? 0 : 38;
            end
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                raw_now ^= 8'h1 << $urandom_range(0, 7);
                if ($urandom_range(0, 1) == 1)
                    raw_now ^= 8'h1 << $urandom_range(0, 7);
            end
            else if (pick < 8)
                raw_now = pcde_pkg::PORT_W'($urandom);
            if ($urandom_range(0, 9) == 0 || gap_ticks > 1000)
                ts_now = $urandom;
            else
                ts_now += $urandom_range(0, 2 * gap_ticks + 3);
            send_sample(raw_now, ts_now, 1'b0, 8'h00);
        end

        drain_events();
        if (expected_events.size() != 0)
            report_mismatch("events never delivered", expected_events.size(), 0);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
